>>> rtl/ace_pkg.sv
// Shared types and constants for the arithmetic coder encode step.
// No dependencies; used by ace_mul, arith_coder_encode_step_core and the testbench.
package ace_pkg;

	// Interval bounds and CDF scale
	localparam logic [31:0] HALF          = 32'h8000_0000;
	localparam logic [31:0] QUARTER       = 32'h4000_0000;
	localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;
	localparam logic [31:0] LOW_MASK      = 32'h7FFF_FFFF;
	localparam logic [31:0] HIGH_FILL     = 32'h8000_0001;
	localparam logic [16:0] TOP_BOUND     = 17'h1_0000;
	localparam int unsigned PREC_BITS     = 16;
	localparam logic [15:0] MAX_SYM_RST   = 16'd65534;

	// Multiplier operand widths: span is 1 .. 2^32, CDF bound is 0 .. 2^16
	localparam int unsigned SPAN_W = 33;
	localparam int unsigned CDF_W  = 17;
	localparam int unsigned PROD_W = SPAN_W + CDF_W;

	// Renormalisation is capped at 32 iterations
	localparam int unsigned ITER_W = 6;

	typedef struct packed {
		logic [15:0] symbol;
		logic [15:0] cdf_at_symbol;
		logic [15:0] cdf_after_symbol;
		logic        flush;
	} ace_in_t;

	typedef struct packed {
		logic        out_bit;
		logic [31:0] follow_count;
		logic        stream_end;
		logic        last;
	} ace_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_ADD_LO,
		ST_RENORM,
		ST_FLUSH,
		ST_FIN
	} ace_state_t;

	// Pending count increment, saturating at all ones
	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		logic [31:0] r;
		r = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
		return r;
	endfunction

endpackage

>>> rtl/arith_coder_encode_step_core.sv
// Arithmetic encoder step: interval narrowing and bit-serial renormalisation.
// Depends on ace_pkg and ace_mul.
//
//  channel | dir | handshake           | payload
//  sym     | in  | sym_valid/sym_stall | ace_in_t  (symbol, cdf bounds, flush)
//  code    | out | code_valid/code_stall | ace_out_t (bit, follow count, end, last)
//  cfg     | in  | cfg_valid/cfg_ready | top symbol, 16 bit
//
// A request narrows the interval in steps (span at acceptance, two passes
// through the shared multiplier, low update), then runs the renormalisation
// iterations (up to 32), leaves the loop and closes (last bit or flush bit);
// when a flush follows emitted bits, the held bit goes out before the flush bit.
// A downstream stall holds the emitting iteration; one decided bit is kept
// back so that the last flag can be set on it.
// Reset: low 0, high all ones, pending 0, top symbol 65534.
module arith_coder_encode_step_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sym_valid,
	output logic             sym_stall,
	input  ace_pkg::ace_in_t sym_data,
	output logic             code_valid,
	input  logic             code_stall,
	output ace_pkg::ace_out_t code_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data
);

	ace_pkg::ace_state_t state_q, state_d;

	logic [15:0] max_sym_q;
	logic [31:0] lo_q, hi_q, pending_q;
	logic [ace_pkg::SPAN_W-1:0] span_q;
	logic [ace_pkg::CDF_W-1:0]  c_lo_q, c_hi_q;
	logic flush_q;
	logic [ace_pkg::ITER_W-1:0] iter_q;

	logic              hold_valid_q;
	ace_pkg::ace_out_t hold_q;
	logic              code_valid_q;
	ace_pkg::ace_out_t code_q;

	logic [ace_pkg::PROD_W-1:0] prod_q;
	logic [31:0] prod_top;
	logic mul_en;

	logic accept, code_free, emit_c, pend_c;
	logic push, emit_step, pend_step, hold_clear, flush_emit, hi_upd, lo_upd;
	ace_pkg::ace_out_t push_data;

	assign accept    = sym_valid && !sym_stall;
	assign sym_stall = (state_q != ace_pkg::ST_IDLE);
	assign cfg_ready = (state_q == ace_pkg::ST_IDLE);
	assign code_valid = code_valid_q;
	assign code_data  = code_q;
	assign code_free  = !code_valid_q || !code_stall;

	// shared multiplier: upper bound first, then lower bound
	ace_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.span   (span_q),
		.bound  ((state_q == ace_pkg::ST_MUL_HI) ? c_hi_q : c_lo_q),
		.prod_q (prod_q)
	);
	assign prod_top = prod_q[ace_pkg::PREC_BITS +: 32];

	// renormalisation decisions on the current bounds
	assign emit_c = (hi_q < ace_pkg::HALF) || (lo_q >= ace_pkg::HALF);
	assign pend_c = (lo_q >= ace_pkg::QUARTER) && (hi_q < ace_pkg::THREE_QUARTER);

	// sequencer
	always_comb begin
		state_d    = state_q;
		mul_en     = 1'b0;
		hi_upd     = 1'b0;
		lo_upd     = 1'b0;
		emit_step  = 1'b0;
		pend_step  = 1'b0;
		hold_clear = 1'b0;
		flush_emit = 1'b0;
		push       = 1'b0;
		push_data  = hold_q;
		case (state_q)
			ace_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ace_pkg::ST_MUL_HI;
				end
			end
			ace_pkg::ST_MUL_HI: begin
				mul_en  = 1'b1;
				state_d = ace_pkg::ST_MUL_LO;
			end
			ace_pkg::ST_MUL_LO: begin
				mul_en  = 1'b1;
				hi_upd  = 1'b1;
				state_d = ace_pkg::ST_ADD_LO;
			end
			ace_pkg::ST_ADD_LO: begin
				lo_upd  = 1'b1;
				state_d = ace_pkg::ST_RENORM;
			end
			ace_pkg::ST_RENORM: begin
				if (iter_q[ace_pkg::ITER_W-1] || !(emit_c || pend_c)) begin
					state_d = flush_q ? ace_pkg::ST_FLUSH : ace_pkg::ST_FIN;
				end else if (emit_c) begin
					// the held bit leaves as the new one takes its place
					if (!hold_valid_q || code_free) begin
						emit_step = 1'b1;
						push      = hold_valid_q;
					end
				end else begin
					pend_step = 1'b1;
				end
			end
			ace_pkg::ST_FLUSH: begin
				if (code_free) begin
					if (hold_valid_q) begin
						push       = 1'b1;
						hold_clear = 1'b1;
					end else begin
						push                   = 1'b1;
						flush_emit             = 1'b1;
						push_data.out_bit      = (lo_q >= ace_pkg::QUARTER);
						push_data.follow_count = ace_pkg::sat_inc(pending_q);
						push_data.stream_end   = 1'b1;
						push_data.last         = 1'b1;
						state_d                = ace_pkg::ST_IDLE;
					end
				end
			end
			ace_pkg::ST_FIN: begin
				if (!hold_valid_q) begin
					state_d = ace_pkg::ST_IDLE;
				end else if (code_free) begin
					push           = 1'b1;
					push_data.last = 1'b1;
					hold_clear     = 1'b1;
					state_d        = ace_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ace_pkg::ST_IDLE;
			end
		endcase
	end

	// control and coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ace_pkg::ST_IDLE;
			max_sym_q    <= ace_pkg::MAX_SYM_RST;
			lo_q         <= '0;
			hi_q         <= '1;
			pending_q    <= '0;
			hold_valid_q <= 1'b0;
			code_valid_q <= 1'b0;
			iter_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				max_sym_q <= cfg_data;
			end
			if (accept) begin
				iter_q <= '0;
			end
			if (hi_upd) begin
				hi_q <= (lo_q - 32'd1) + prod_top;
			end
			if (lo_upd) begin
				lo_q <= lo_q + prod_top;
			end
			if (emit_step) begin
				pending_q    <= '0;
				lo_q         <= {lo_q[30:0], 1'b0};
				hi_q         <= {hi_q[30:0], 1'b1};
				hold_valid_q <= 1'b1;
				iter_q       <= iter_q + ace_pkg::ITER_W'(1);
			end else if (pend_step) begin
				pending_q <= ace_pkg::sat_inc(pending_q);
				lo_q      <= {lo_q[30:0], 1'b0} & ace_pkg::LOW_MASK;
				hi_q      <= {hi_q[30:0], 1'b0} | ace_pkg::HIGH_FILL;
				iter_q    <= iter_q + ace_pkg::ITER_W'(1);
			end
			if (hold_clear) begin
				hold_valid_q <= 1'b0;
			end
			if (flush_emit) begin
				pending_q <= '0;
			end
			// output register
			if (push) begin
				code_valid_q <= 1'b1;
			end else if (!code_stall) begin
				code_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			span_q  <= {1'b0, hi_q} - {1'b0, lo_q} + ace_pkg::SPAN_W'(1);
			c_lo_q  <= {1'b0, sym_data.cdf_at_symbol};
			c_hi_q  <= (sym_data.symbol == max_sym_q) ? ace_pkg::TOP_BOUND :
				{1'b0, sym_data.cdf_after_symbol};
			flush_q <= sym_data.flush;
		end
		if (emit_step) begin
			hold_q.out_bit      <= !(hi_q < ace_pkg::HALF);
			hold_q.follow_count <= pending_q;
			hold_q.stream_end   <= 1'b0;
			hold_q.last         <= 1'b0;
		end
		if (push) begin
			code_q <= push_data;
		end
	end

	// nothing is held back between requests
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ace_pkg::ST_IDLE) |-> !hold_valid_q)
		else $error("held code bit left over in idle");

	// renormalisation leaves low below half and high at or above half
	a_renorm_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ace_pkg::ST_FIN || state_q == ace_pkg::ST_FLUSH) |->
		(lo_q < ace_pkg::HALF) && (hi_q >= ace_pkg::HALF))
		else $error("bounds not renormalised");

	// the closing result of a request returns the sequencer to idle
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.last) |=> (state_q == ace_pkg::ST_IDLE))
		else $error("last result without return to idle");

	// the terminating emission clears the pending count
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		flush_emit |=> (pending_q == '0))
		else $error("pending count not cleared by flush");

	// a result is only loaded when the output register is free
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> code_free)
		else $error("output register overwritten");

endmodule

>>> rtl/ace_mul.sv
// Shared 33x17 unsigned multiplier with registered product.
// Depends on ace_pkg for operand widths.
module ace_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ace_pkg::SPAN_W-1:0]  span,
	input  logic [ace_pkg::CDF_W-1:0]   bound,
	output logic [ace_pkg::PROD_W-1:0]  prod_q
);

	// one product per enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= ace_pkg::PROD_W'(span) * ace_pkg::PROD_W'(bound);
		end
	end

endmodule

>>> tb/ace_code_checker.sv
// Checker for the arithmetic coder encode step: follows the sym, code and cfg
// channels, predicts the code bits of every accepted request and compares them.
// Depends on ace_pkg for the payload types and interval constants.
module ace_code_checker
	import ace_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sym_valid,
	input  logic     sym_stall,
	input  ace_in_t  sym_data,
	input  logic     code_valid,
	input  logic     code_stall,
	input  ace_out_t code_data,
	input  logic     cfg_valid,
	input  logic     cfg_ready,
	input  logic [15:0] cfg_data,
	output int       mismatches,
	output int       codes_waiting,
	output int       codes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted coder state and register copy
	logic [31:0] iv_low;
	logic [31:0] iv_high;
	logic [31:0] follow_pend;
	logic [15:0] max_sym;

	ace_out_t expected_codes[$];
	ace_out_t want;
	int       err_cnt;
	int       seen_cnt;

	// Narrow the interval for one request, renormalise and queue the code bits
	task automatic narrow_and_renorm(input ace_in_t req);
		logic [63:0] span;
		logic [63:0] upper;
		logic [63:0] prod_hi;
		logic [63:0] prod_lo;
		logic [31:0] lo;
		logic [31:0] hi;
		ace_out_t    code;
		ace_out_t    batch[$];
		int          step;
		bit          done;

		upper = (req.symbol == max_sym) ? 64'h1_0000 : {48'd0, req.cdf_after_symbol};
		span = {32'd0, iv_high} - {32'd0, iv_low} + 64'd1;
		prod_hi = span * upper;
		prod_lo = span * {48'd0, req.cdf_at_symbol};
		hi = (iv_low - 32'd1) + prod_hi[47:16];
		lo = iv_low + prod_lo[47:16];

		done = 1'b0;
		for (step = 0; step < 32 && !done; step++) begin
			if (hi < HALF || lo >= HALF) begin
				// bit decided: emit it with the pending count
				code.out_bit      = (hi < HALF) ? 1'b0 : 1'b1;
				code.follow_count = follow_pend;
				code.stream_end   = 1'b0;
				code.last         = 1'b0;
				batch.push_back(code);
				follow_pend = '0;
				lo = lo << 1;
				hi = (hi << 1) | 32'd1;
			end else if (lo >= QUARTER && hi < THREE_QUARTER) begin
				// straddling the middle: defer as a pending bit
				if (follow_pend != 32'hFFFF_FFFF)
					follow_pend = follow_pend + 32'd1;
				lo = (lo << 1) & LOW_MASK;
				hi = (hi << 1) | HIGH_FILL;
			end else begin
				done = 1'b1;
			end
		end

		// closing bit of the stream
		if (req.flush) begin
			if (follow_pend != 32'hFFFF_FFFF)
				follow_pend = follow_pend + 32'd1;
			code.out_bit      = (lo < QUARTER) ? 1'b0 : 1'b1;
			code.follow_count = follow_pend;
			code.stream_end   = 1'b1;
			code.last         = 1'b0;
			batch.push_back(code);
			follow_pend = '0;
		end

		iv_low  = lo;
		iv_high = hi;
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			expected_codes.push_back(batch[k]);
	endtask

	// Channel monitor: code results first, then register writes, then requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_low      = '0;
			iv_high     = 32'hFFFF_FFFF;
			follow_pend = '0;
			max_sym     = MAX_SYM_RST;
			expected_codes.delete();
			err_cnt  = 0;
			seen_cnt = 0;
		end else begin
			if (code_valid && !code_stall) begin
				seen_cnt++;
				if (expected_codes.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected code result bit=%0d follow=%0d end=%0d last=%0d",
						$time, code_data.out_bit, code_data.follow_count,
						code_data.stream_end, code_data.last);
				end else begin
					want = expected_codes.pop_front();
					if (code_data.out_bit !== want.out_bit
							|| code_data.follow_count !== want.follow_count
							|| code_data.stream_end !== want.stream_end
							|| code_data.last !== want.last) begin
						err_cnt++;
						$display("%0t: code mismatch: expected bit=%0d follow=%0d end=%0d last=%0d",
							$time, want.out_bit, want.follow_count, want.stream_end, want.last);
						$display("%0t:                actual   bit=%0d follow=%0d end=%0d last=%0d",
							$time, code_data.out_bit, code_data.follow_count,
							code_data.stream_end, code_data.last);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				max_sym = cfg_data;
			if (sym_valid && !sym_stall)
				narrow_and_renorm(sym_data);
		end
		mismatches    <= err_cnt;
		codes_waiting <= expected_codes.size();
		codes_seen    <= seen_cnt;
	end

endmodule

>>> tb/arith_coder_encode_step_core_tb.sv
// Top of the encode step testbench: clock, reset, request and register
// stimulus, random back-pressure and the verdict.
// Depends on ace_pkg, arith_coder_encode_step_core and ace_code_checker.
module arith_coder_encode_step_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ace_pkg::*;

	localparam int PHASE_REQS  = 58;
	localparam int SETTLE_CYC  = 60;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        sym_valid  = 1'b0;
	logic        sym_stall;
	ace_in_t     sym_data   = '0;
	logic        code_valid;
	logic        code_stall = 1'b0;
	ace_out_t    code_data;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data   = '0;

	int          mismatches;
	int          codes_waiting;
	int          codes_seen;

	logic [15:0] cur_max  = MAX_SYM_RST;
	bit          calm     = 1'b0;
	int          req_cnt  = 0;
	int          flush_cnt = 0;
	int          cfg_cnt  = 0;

	arith_coder_encode_step_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym_data   (sym_data),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_data  (code_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	ace_code_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.sym_valid     (sym_valid),
		.sym_stall     (sym_stall),
		.sym_data      (sym_data),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.code_data     (code_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.codes_waiting (codes_waiting),
		.codes_seen    (codes_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs
	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic ace_in_t make_req(input logic [15:0] sym, input logic [15:0] at,
			input logic [15:0] after, input logic fl);
		ace_in_t r;
		r.symbol           = sym;
		r.cdf_at_symbol    = at;
		r.cdf_after_symbol = after;
		r.flush            = fl;
		return r;
	endfunction

	// Mostly well-formed intervals, some top symbols, mid-straddles and noise
	function automatic ace_in_t random_req();
		ace_in_t r;
		int      kind;
		int      w;
		int      a;
		kind = $urandom_range(0, 99);
		r.symbol           = 16'($urandom_range(0, 65534));
		r.cdf_at_symbol    = 16'($urandom);
		r.cdf_after_symbol = 16'($urandom);
		r.flush            = ($urandom_range(0, 11) == 0);
		if (kind < 55) begin
			w = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 65535);
			a = $urandom_range(0, 65535 - w);
			r.cdf_at_symbol    = 16'(a);
			r.cdf_after_symbol = 16'(a + w);
		end else if (kind < 70) begin
			r.symbol = cur_max;
		end else if (kind < 85) begin
			r.cdf_at_symbol    = 16'(32768 - $urandom_range(1, 64));
			r.cdf_after_symbol = 16'(32768 + $urandom_range(0, 64));
		end
		return r;
	endfunction

	// One request; valid stays high after acceptance unless the next one waits
	task automatic send_req(input ace_in_t r);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			sym_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sym_valid <= 1'b1;
		sym_data  <= r;
		do @(posedge clk); while (sym_stall);
		req_cnt++;
		if (r.flush)
			flush_cnt++;
	endtask

	task automatic drain_codes();
		sym_valid <= 1'b0;
		do @(posedge clk); while (codes_waiting != 0);
	endtask

	// Register write only once the block has gone quiet
	task automatic write_max_sym(input logic [15:0] v);
		drain_codes();
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_max = v;
		cfg_cnt++;
	endtask

	// Downstream back-pressure
	initial begin
		int n;
		forever begin
			n = draw_wait();
			if (n > 0) begin
				code_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			code_stall <= 1'b0;
			do @(posedge clk); while (!code_valid);
		end
	end

	// Stimulus and verdict
	initial begin
		logic [15:0] settings[6];
		settings[0] = 16'd0;
		settings[1] = 16'($urandom_range(1, 65533));
		settings[2] = 16'd65534;
		settings[3] = 16'h5555;
		settings[4] = 16'hAAAA;
		settings[5] = 16'($urandom_range(0, 65534));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes at the reset top symbol
		send_req(make_req(16'd0, 16'h0000, 16'h0001, 1'b0));     // tiny, bottom: run of zeros
		send_req(make_req(16'd65534, 16'hFFFF, 16'h0000, 1'b0)); // top symbol: run of ones
		send_req(make_req(16'd1, 16'h0000, 16'hFFFF, 1'b0));     // near full width: no output
		send_req(make_req(16'd2, 16'h7FFF, 16'h8001, 1'b0));     // straddles middle: pending
		send_req(make_req(16'd3, 16'h7FFF, 16'h8001, 1'b1));     // pending then flush
		send_req(make_req(16'h5555, 16'hFFFF, 16'h0000, 1'b0));  // decreasing cdf wraps
		send_req(make_req(16'hAAAA, 16'h1234, 16'h1234, 1'b0));  // empty interval
		send_req(make_req(16'd4, 16'h0000, 16'hFFFF, 1'b1));     // flush on wide interval
		send_req(make_req(16'd4, 16'h0000, 16'hFFFF, 1'b1));     // back-to-back flush
		send_req(make_req(16'd65534, 16'h0000, 16'hFFFF, 1'b0)); // top symbol, bound ignored
		send_req(make_req(16'd65534, 16'h8000, 16'h1234, 1'b1));
		send_req(make_req(16'h7FFF, 16'h4000, 16'hC000, 1'b0));
		send_req(make_req(16'd5, 16'h3FFF, 16'h4001, 1'b0));
		send_req(make_req(16'd6, 16'hBFFF, 16'hC001, 1'b1));
		send_req(make_req(16'd7, 16'hFFFE, 16'hFFFF, 1'b0));
		send_req(make_req(16'h8000, 16'hFFFF, 16'hFFFF, 1'b1));

		// random phases, one top-symbol setting each
		foreach (settings[p]) begin
			write_max_sym(settings[p]);
			for (int i = 0; i < PHASE_REQS; i++) begin
				if (i % 20 == 0)
					calm = ($urandom_range(0, 3) == 0);
				// in odd phases, hold off mid-phase until all outstanding codes are out
				if (i == PHASE_REQS / 2 && p % 2 == 1)
					drain_codes();
				send_req(random_req());
			end
		end

		drain_codes();
		repeat (SETTLE_CYC) @(posedge clk);

		$display("Coded %0d requests (%0d flushes) across %0d top-symbol settings;",
			req_cnt, flush_cnt, cfg_cnt);
		$display("checked %0d code bits against the predicted stream.", codes_seen);
		if (mismatches == 0 && codes_waiting == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/ace_pkg.sv
rtl/ace_mul.sv
rtl/arith_coder_encode_step_core.sv
tb/ace_code_checker.sv
tb/arith_coder_encode_step_core_tb.sv
